@@ rtl/ghist_pkg.sv @@
// Shared types and constants for the gated channel histogram.
`timescale 1ns / 1ps
`default_nettype none

package ghist_pkg;

    localparam int NUM_CHANNELS = 128;
    localparam int COUNT_WIDTH  = 32;
    localparam int CH_AW        = $clog2(NUM_CHANNELS);

    localparam int CHANNEL_W   = 7;
    localparam int TIME_W      = 32;
    localparam int BIN_COUNT_W = 32;

    // word layouts: fields packed from bit 0, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CH_AW-1:0]       addr_t;

    typedef enum logic [1:0] {
        CFG_WINDOW_START = 2'd0,
        CFG_WINDOW_END   = 2'd1,
        CFG_BAND_FIRST   = 2'd2,
        CFG_BAND_LAST    = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        FUNC_RECORD = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    typedef struct packed {
        logic in_time;
        logic in_band;
        logic in_range;
    } gate_t;

endpackage

`default_nettype wire

@@ rtl/ghist_store.sv @@
// Counter store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ghist_store (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            rd_en,
    input  wire ghist_pkg::addr_t  rd_addr,
    output      ghist_pkg::count_t rd_data,
    input  wire logic            wr_en,
    input  wire ghist_pkg::addr_t  wr_addr,
    input  wire ghist_pkg::count_t wr_data
);
    import ghist_pkg::*;

    count_t                  mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    count_t                  rdata_reg;
    logic                    rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // an entry never written since reset reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

@@ rtl/ghist_cfg.sv @@
// Window and band registers plus the time, band and range gate checks.
`timescale 1ns / 1ps
`default_nettype none

module ghist_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [1:0]                         wr_index,
    input  wire logic [31:0]                        wr_data,
    input  wire logic [ghist_pkg::TIME_W-1:0]       event_time,
    input  wire logic [ghist_pkg::CHANNEL_W-1:0]    channel,
    output      ghist_pkg::gate_t                   gate
);
    import ghist_pkg::*;

    logic [TIME_W-1:0]    window_start_reg;
    logic [TIME_W-1:0]    window_end_reg;
    logic [CHANNEL_W-1:0] band_first_reg;
    logic [CHANNEL_W-1:0] band_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= {1'b1, {(TIME_W-1){1'b0}}};
            window_end_reg   <= {1'b0, {(TIME_W-1){1'b1}}};
            band_first_reg   <= '0;
            band_last_reg    <= '1;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_WINDOW_START: window_start_reg <= wr_data[TIME_W-1:0];
                CFG_WINDOW_END:   window_end_reg   <= wr_data[TIME_W-1:0];
                CFG_BAND_FIRST:   band_first_reg   <= wr_data[CHANNEL_W-1:0];
                CFG_BAND_LAST:    band_last_reg    <= wr_data[CHANNEL_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        gate.in_time  = ($signed(event_time) >= $signed(window_start_reg)) &&
                        ($signed(event_time) <= $signed(window_end_reg));
        gate.in_band  = (channel >= band_first_reg) && (channel <= band_last_reg);
        gate.in_range = (32'(channel) < 32'(NUM_CHANNELS));
    end

endmodule

`default_nettype wire

@@ rtl/gated_channel_histogram_unit.sv @@
// Top level: stream ports, read-modify-write pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

// Gated multichannel analyzer histogram. Each input word either records an
// event (tuser = 0: counted in its channel when its time lies in the inclusive
// window and its channel in the inclusive band, saturating) or reads and
// clears one bin (tuser = 1). Exactly one output word per input word, in
// order. One word is taken per cycle while results are taken; the input stalls
// only when the read stage holds a word and the result register is full and
// not being taken. A result is presented once its word leaves the read stage:
// the counter store is read at the accepting edge, and the edge on which the
// word leaves the read stage writes the increment or clear back and registers
// the result. Back-to-back hits on the same bin are served by forwarding the
// value being written. The store is empty right after reset: per-bin valid
// bits stand in for a clearing pass, so input is taken from the first cycle.
module gated_channel_histogram_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input words
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    input  wire logic [ghist_pkg::IN_TDATA_W-1:0]     s_tdata,  // event_time[31:0], channel[38:32]
    input  wire logic                                 s_tuser,  // func
    // result words
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    output      logic [ghist_pkg::OUT_TDATA_W-1:0]    m_tdata,  // accepted[0], bin_count[32:1]
    // register writes
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [31:0]                          cfg_data
);
    import ghist_pkg::*;

    logic [TIME_W-1:0]    in_time;
    logic [CHANNEL_W-1:0] in_channel;
    gate_t                gate;
    logic                 in_accept;
    addr_t                in_addr;

    // read stage
    logic                 s1_valid_reg;
    func_t                s1_func_reg;
    addr_t                s1_addr_reg;
    logic                 s1_range_reg;
    logic                 s1_pass_reg;
    logic                 fwd_hit_reg;
    count_t               fwd_data_reg;
    logic                 s1_adv;

    count_t               rd_data;
    count_t               cur;
    logic                 wr_en;
    count_t               wr_data;
    logic                 res_accepted;
    logic [BIN_COUNT_W-1:0] res_count;

    logic                 m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    assign in_time    = s_tdata[TIME_W-1:0];
    assign in_channel = s_tdata[TIME_W +: CHANNEL_W];
    assign in_addr    = CH_AW'(in_channel);

    assign cfg_ready = 1'b1;

    ghist_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg_valid),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .event_time (in_time),
        .channel    (in_channel),
        .gate       (gate)
    );

    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign in_accept = s_tvalid && s_tready;

    ghist_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    // a write landing on the bin read in the same cycle misses the read data
    assign cur = fwd_hit_reg ? fwd_data_reg : rd_data;

    always_comb
    begin
        wr_data      = '0;
        res_accepted = 1'b0;
        res_count    = '0;
        wr_en        = 1'b0;
        case (s1_func_reg)
            FUNC_READ:
            begin
                wr_en = s1_adv && s1_range_reg;
                if (s1_range_reg)
                begin
                    res_count = BIN_COUNT_W'(cur);
                end
            end
            FUNC_RECORD:
            begin
                wr_en        = s1_adv && s1_pass_reg;
                res_accepted = s1_pass_reg;
                wr_data      = (cur == '1) ? cur : cur + 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (s1_addr_reg == in_addr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg  <= func_t'(s_tuser);
            s1_addr_reg  <= in_addr;
            s1_range_reg <= gate.in_range;
            s1_pass_reg  <= gate.in_time && gate.in_band && gate.in_range;
            fwd_data_reg <= wr_data;
        end
        if (s1_adv)
        begin
            m_data_reg <= OUT_TDATA_W'({res_count, res_accepted});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // the store is written only as an item leaves the read stage
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> s1_valid_reg)
        else $error("store write without an item in the read stage");

    // a stalled read stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("read stage item lost while stalled");

    // a same-bin write in the accepting cycle sets the forward flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && wr_en && (s1_addr_reg == in_addr)) |=> fwd_hit_reg)
        else $error("same-bin overlap not forwarded");

    // an event result never carries a count, a read result is never accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg[0] && (m_data_reg[BIN_COUNT_W:1] != '0)))
        else $error("result has both accepted and a count");

endmodule

`default_nettype wire

@@ bench/tb_gated_channel_histogram_unit.sv @@
// Self-checking testbench for the gated channel histogram unit.
`timescale 1ns / 1ps

module tb_gated_channel_histogram_unit;

    import ghist_pkg::*;

    typedef struct packed {
        logic        accepted;
        logic [31:0] bin_count;
    } result_t;

    // one row of the directed table: a register write or an input word
    typedef struct {
        bit          is_reg;
        cfg_idx_t    idx;
        logic [31:0] value;
        func_t       func;
        logic [31:0] event_time;
        logic [6:0]  channel;
        bit          typed;
        result_t     typed_result;
    } stim_step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // event_time[31:0], channel[38:32]
    logic                   s_tuser;   // func
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // accepted[0], bin_count[32:1]
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [31:0]            cfg_data;

    // histogram model: bins and gate settings
    logic [COUNT_WIDTH-1:0] bin_model [NUM_CHANNELS];
    logic signed [31:0]     win_lo;
    logic signed [31:0]     win_hi;
    logic [6:0]             band_lo;
    logic [6:0]             band_hi;

    result_t    pending_results[$];
    stim_step_t directed_steps[$];
    int         mismatches;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         stall_cycles;

    gated_channel_histogram_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic stim_step_t word_row(func_t f, logic [31:0] t, logic [6:0] ch,
                                            bit typed, logic acc, logic [31:0] cnt);
        stim_step_t s;
        s.is_reg       = 1'b0;
        s.idx          = CFG_WINDOW_START;
        s.value        = '0;
        s.func         = f;
        s.event_time   = t;
        s.channel      = ch;
        s.typed        = typed;
        s.typed_result = '{accepted: acc, bin_count: cnt};
        return s;
    endfunction

    function automatic stim_step_t reg_row(cfg_idx_t idx, logic [31:0] v);
        stim_step_t s;
        s       = word_row(FUNC_RECORD, '0, '0, 1'b0, 1'b0, '0);
        s.is_reg = 1'b1;
        s.idx    = idx;
        s.value  = v;
        return s;
    endfunction

    // gate the event, bump or read-and-clear the bin
    function automatic result_t tally_word(func_t f, logic signed [31:0] t, logic [6:0] ch);
        result_t r;
        r = '0;
        if (f == FUNC_READ)
        begin
            if (int'(ch) < NUM_CHANNELS)
            begin
                r.bin_count   = bin_model[ch][31:0];
                bin_model[ch] = '0;
            end
        end
        else if (t >= win_lo && t <= win_hi && ch >= band_lo && ch <= band_hi &&
                 int'(ch) < NUM_CHANNELS)
        begin
            r.accepted = 1'b1;
            if (bin_model[ch] != '1)
                bin_model[ch] = bin_model[ch] + 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
    endtask

    task automatic send_word(func_t f, logic [31:0] t, logic [6:0] ch,
                             bit typed, result_t typed_result);
        result_t r;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ch, t};
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = tally_word(f, t, ch);
        pending_results.push_back(typed ? typed_result : r);
    endtask

    // wait until every result is back and the pipeline has emptied
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_WINDOW_START: win_lo  = v;
            CFG_WINDOW_END:   win_hi  = v;
            CFG_BAND_FIRST:   band_lo = v[6:0];
            CFG_BAND_LAST:    band_hi = v[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", '0, m_tdata[31:0]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.accepted)
                    report_mismatch("accepted", want.accepted, m_tdata[0]);
                if (m_tdata[32:1] !== want.bin_count)
                    report_mismatch("bin_count", want.bin_count, m_tdata[32:1]);
                if (m_tdata[OUT_TDATA_W-1:33] !== '0)
                    report_mismatch("padding", '0, m_tdata[OUT_TDATA_W-1:33]);
            end
        end
    end

    // receiver: random holds plus long hold-offs on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_cycles > 0)
            begin
                m_tready <= 1'b0;
                stall_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        stim_step_t         st;
        func_t              f;
        logic signed [31:0] t;
        logic [6:0]         ch;
        logic [6:0]         last_ch;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [6:0]         c0;
        logic [6:0]         c1;
        longint             span;
        int                 sel;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        tx_idle_pct  = 14;
        rx_idle_pct  = 59;
        stall_cycles = 0;
        last_ch      = '0;
        win_lo       = 32'sh8000_0000;
        win_hi       = 32'sh7FFF_FFFF;
        band_lo      = 7'd0;
        band_hi      = 7'd127;
        for (int i = 0; i < NUM_CHANNELS; i++)
            bin_model[i] = '0;

        // directed table
        directed_steps.push_back(word_row(FUNC_READ,   32'h0000_0000, 7'd0,   1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'h8000_0000, 7'd0,   1, 1'b1, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'h7FFF_FFFF, 7'd127, 1, 1'b1, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'h0000_0000, 7'd127, 0, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_READ,   32'h0000_0000, 7'd127, 1, 1'b0, 32'd2));
        directed_steps.push_back(word_row(FUNC_READ,   32'h0000_0000, 7'd127, 1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_READ,   32'hFFFF_FFFF, 7'd0,   1, 1'b0, 32'd1));
        // back-to-back hits on one bin exercise forwarding
        directed_steps.push_back(word_row(FUNC_RECORD, 32'hFFFF_FFFF, 7'd85,  0, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'hFFFF_FFFF, 7'd85,  0, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'hFFFF_FFFF, 7'd85,  0, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_READ,   32'h0000_0000, 7'd85,  1, 1'b0, 32'd3));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'h0000_0001, 7'd85,  0, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_READ,   32'h0000_0000, 7'd85,  1, 1'b0, 32'd1));
        // window [-100, 100], band [10, 20]: edges of both gates
        directed_steps.push_back(reg_row(CFG_WINDOW_START, 32'hFFFF_FF9C));
        directed_steps.push_back(reg_row(CFG_WINDOW_END,   32'd100));
        directed_steps.push_back(reg_row(CFG_BAND_FIRST,   32'd10));
        directed_steps.push_back(reg_row(CFG_BAND_LAST,    32'd20));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'hFFFF_FF9C, 7'd10,  1, 1'b1, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'hFFFF_FF9B, 7'd10,  1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'd100,       7'd20,  0, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'd101,       7'd20,  1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'd0,         7'd9,   1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'd0,         7'd21,  1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_READ,   32'd0,         7'd10,  1, 1'b0, 32'd1));
        directed_steps.push_back(word_row(FUNC_READ,   32'd0,         7'd20,  0, 1'b0, 32'd0));
        // empty window
        directed_steps.push_back(reg_row(CFG_WINDOW_START, 32'd5));
        directed_steps.push_back(reg_row(CFG_WINDOW_END,   32'd4));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'd4,         7'd15,  1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'd5,         7'd15,  1, 1'b0, 32'd0));
        // empty band
        directed_steps.push_back(reg_row(CFG_WINDOW_START, 32'h8000_0000));
        directed_steps.push_back(reg_row(CFG_WINDOW_END,   32'h7FFF_FFFF));
        directed_steps.push_back(reg_row(CFG_BAND_FIRST,   32'd30));
        directed_steps.push_back(reg_row(CFG_BAND_LAST,    32'd29));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'd0,         7'd29,  1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_RECORD, 32'd0,         7'd30,  1, 1'b0, 32'd0));
        directed_steps.push_back(word_row(FUNC_READ,   32'd0,         7'd15,  1, 1'b0, 32'd0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_steps[i])
        begin
            st = directed_steps[i];
            if (st.is_reg)
            begin
                drain();
                write_reg(st.idx, st.value);
            end
            else
            begin
                send_word(st.func, st.event_time, st.channel, st.typed, st.typed_result);
            end
        end

        // random part: nine gate settings, three idling regimes
        for (int ph = 0; ph < 9; ph++)
        begin
            drain();
            tx_idle_pct = (ph < 3) ? 14 : (ph < 6) ? 59 : 0;
            rx_idle_pct = (ph < 3) ? 59 : (ph < 6) ? 14 : 0;
            a  = $urandom;
            b  = $urandom;
            c0 = 7'($urandom_range(127));
            c1 = 7'($urandom_range(127));
            if ($urandom_range(1) == 1)
                b = a + $urandom_range(2000);
            if (a > b && ph != 3)
            begin
                {a, b} = {b, a};
            end
            if (c0 > c1 && $urandom_range(3) != 0)
            begin
                {c0, c1} = {c1, c0};
            end
            case (ph)
                0:
                begin
                    a = 32'sh8000_0000; b = 32'sh7FFF_FFFF; c0 = 7'd0;   c1 = 7'd127;
                end
                1:
                begin
                    a = 32'sh7FFF_FFFF; b = 32'sh7FFF_FFFF; c0 = 7'd127; c1 = 7'd127;
                end
                2:
                begin
                    a = 32'sh8000_0000; b = 32'sh8000_0000; c0 = 7'd0;   c1 = 7'd0;
                end
                3:
                begin
                    if (a <= b)
                        a = b + 1;
                end
                default: ;
            endcase
            write_reg(CFG_WINDOW_START, a);
            write_reg(CFG_WINDOW_END,   b);
            write_reg(CFG_BAND_FIRST,   {25'd0, c0});
            write_reg(CFG_BAND_LAST,    {25'd0, c1});

            for (int i = 0; i < 200; i++)
            begin
                // long receiver hold-off so the pipeline backs up
                if (i == 100 && ph % 3 == 1)
                    stall_cycles = 250;
                f   = ($urandom_range(99) < 20) ? FUNC_READ : FUNC_RECORD;
                sel = $urandom_range(9);
                if (sel < 5 && win_lo <= win_hi)
                begin
                    span = longint'(win_hi) - longint'(win_lo);
                    t = 32'(longint'(win_lo) + (longint'($urandom) % (span + 1)));
                end
                else if (sel < 7)
                begin
                    case ($urandom_range(3))
                        0: t = win_lo - 1;
                        1: t = win_lo;
                        2: t = win_hi;
                        default: t = win_hi + 1;
                    endcase
                end
                else
                begin
                    t = $urandom;
                end
                sel = $urandom_range(9);
                if (sel < 3)
                    ch = last_ch;
                else if (sel < 8 && band_lo <= band_hi)
                    ch = 7'($urandom_range(band_hi, band_lo));
                else
                    ch = 7'($urandom_range(127));
                last_ch = ch;
                send_word(f, t, ch, 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ghist_pkg.sv
rtl/ghist_store.sv
rtl/ghist_cfg.sv
rtl/gated_channel_histogram_unit.sv
bench/tb_gated_channel_histogram_unit.sv
